### rtl/pls_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies; imported by pls_ram users and the top level.
package pls_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int POS_W      = 5;
   localparam int COUNT_W    = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_FIND   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_BAD_POS = 2'd1,
      STAT_EMPTY   = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

endpackage

### rtl/pls_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependencies.
module pls_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/positional_list_store_core.sv
// Positional list store: ordered list of signed words held in a RAM.
// Depends on pls_pkg and pls_ram.
//
// Usage:
//   Command channel: drive req_opcode, req_position and req_value with start
//   high; the word is taken at a clock edge where busy is low. busy stays
//   high until the operation is done.
//   Response channel: rsp_strobe is high for exactly one cycle with the
//   result word on the rsp_ ports. The receiver cannot stall; it must take
//   the word in that cycle.
//   Steps per command:
//     rejected command (bad position, empty, full): answered from idle
//     insert at p with n entries: p..n-1 moved up one, top first, then p
//     remove at p with n entries: p+1..n-1 moved down one, lowest first
//     read: one RAM read of entry p
//     find: reads from entry 0 upward, ends early at the first match
//   Run time is set by the single RAM read port: each moved or searched
//   entry costs one read.
//   A new command may be issued in the cycle the strobe is shown.
//   Reset empties the list (count goes to zero); RAM contents are not
//   cleared, entries at or above the count are never read.
module positional_list_store_core
   import pls_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic [POS_W-1:0]             req_position,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_read_value,
   output logic                         rsp_found,
   output logic [POS_W-1:0]             rsp_found_position,
   output logic [COUNT_W-1:0]           rsp_count,
   output logic                         rsp_is_empty,
   output logic [1:0]                   rsp_status
);

   typedef enum logic {S_IDLE, S_RUN} state_type;

   state_type                 state_ff, state_in;
   opcode_type                op_ff, op_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]     value_ff, value_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [POS_W-1:0]          cur_ff, cur_in;
   logic [POS_W-1:0]          last_ff, last_in;
   logic                      more_ff, more_in;
   logic                      pend_ff, pend_in;
   logic [POS_W-1:0]          paddr_ff, paddr_in;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_WIDTH-1:0]     rsp_read_value_ff, rsp_read_value_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]          rsp_found_position_ff, rsp_found_position_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_is_empty_ff, rsp_is_empty_in;
   status_type                rsp_status_ff, rsp_status_in;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0]     wr_data;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0]     rd_data;

   opcode_type                req_op;
   logic                      accept;
   logic                      hit;
   logic                      finish;
   logic [COUNT_W-1:0]        new_count;

   pls_ram #(
      .DEPTH(CAPACITY),
      .WIDTH(DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_op = opcode_type'(req_opcode);
   assign accept = start && (state_ff == S_IDLE);

   // read one entry per cycle; the word read last cycle is written back
   // two slots away from the current read, so the ports never collide
   assign rd_en   = (state_ff == S_RUN) && more_ff;
   assign rd_addr = cur_ff[ADDR_W-1:0];
   assign hit     = (state_ff == S_RUN) && pend_ff && (op_ff == OP_FIND) &&
                    (rd_data == value_ff);
   assign finish  = (state_ff == S_RUN) && ((!more_ff && !pend_ff) || hit);

   always_comb begin
      case (op_ff)
         OP_INSERT: new_count = count_ff + COUNT_W'(1);
         OP_REMOVE: new_count = count_ff - COUNT_W'(1);
         default:   new_count = count_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(paddr_ff);
      wr_data = rd_data;
      if (state_ff == S_RUN) begin
         if (pend_ff && op_ff == OP_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(paddr_ff + POS_W'(1));
         end else if (pend_ff && op_ff == OP_REMOVE) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(paddr_ff - POS_W'(1));
         end else if (finish && op_ff == OP_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(pos_ff);
            wr_data = value_ff;
         end
      end
   end

   always_comb begin
      state_in              = state_ff;
      op_in                 = op_ff;
      pos_in                = pos_ff;
      value_in              = value_ff;
      count_in              = count_ff;
      cur_in                = cur_ff;
      last_in               = last_ff;
      more_in               = more_ff;
      pend_in               = 1'b0;
      paddr_in              = paddr_ff;
      rsp_strobe_in         = 1'b0;
      rsp_read_value_in     = rsp_read_value_ff;
      rsp_found_in          = rsp_found_ff;
      rsp_found_position_in = rsp_found_position_ff;
      rsp_count_in          = rsp_count_ff;
      rsp_is_empty_in       = rsp_is_empty_ff;
      rsp_status_in         = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in                 = req_op;
               pos_in                = req_position;
               value_in              = req_value;
               rsp_read_value_in     = '0;
               rsp_found_in          = 1'b0;
               rsp_found_position_in = '0;
               rsp_count_in          = count_ff;
               rsp_is_empty_in       = (count_ff == '0);
               rsp_status_in         = STAT_OK;
               case (req_op)
                  OP_INSERT: begin
                     cur_in  = count_ff - COUNT_W'(1);
                     last_in = req_position;
                     more_in = (req_position < count_ff);
                     if (req_position > count_ff) begin
                        rsp_status_in = STAT_BAD_POS;
                     end else if (count_ff == COUNT_W'(CAPACITY)) begin
                        rsp_status_in = STAT_FULL;
                     end
                  end
                  OP_REMOVE: begin
                     cur_in  = req_position + POS_W'(1);
                     last_in = count_ff - COUNT_W'(1);
                     more_in = ((req_position + POS_W'(1)) < count_ff);
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (req_position >= count_ff) begin
                        rsp_status_in = STAT_BAD_POS;
                     end
                  end
                  OP_READ: begin
                     cur_in  = req_position;
                     last_in = req_position;
                     more_in = 1'b1;
                     if (req_position >= count_ff) begin
                        rsp_status_in = STAT_BAD_POS;
                     end
                  end
                  default: begin
                     cur_in  = '0;
                     last_in = count_ff - COUNT_W'(1);
                     more_in = (count_ff != '0);
                  end
               endcase
               if (rsp_status_in != STAT_OK) begin
                  rsp_strobe_in = 1'b1;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (more_ff) begin
               pend_in  = 1'b1;
               paddr_in = cur_ff;
               more_in  = (cur_ff != last_ff);
               cur_in   = (op_ff == OP_INSERT) ? cur_ff - POS_W'(1)
                                               : cur_ff + POS_W'(1);
            end
            if (pend_ff && op_ff == OP_READ) begin
               rsp_read_value_in = rd_data;
            end
            if (hit) begin
               rsp_found_in          = 1'b1;
               rsp_found_position_in = paddr_ff;
            end
            if (finish) begin
               state_in        = S_IDLE;
               more_in         = 1'b0;
               pend_in         = 1'b0;
               count_in        = new_count;
               rsp_count_in    = new_count;
               rsp_is_empty_in = (new_count == '0);
               rsp_strobe_in   = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         more_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         more_ff       <= more_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff                 <= op_in;
      pos_ff                <= pos_in;
      value_ff              <= value_in;
      cur_ff                <= cur_in;
      last_ff               <= last_in;
      paddr_ff              <= paddr_in;
      rsp_read_value_ff     <= rsp_read_value_in;
      rsp_found_ff          <= rsp_found_in;
      rsp_found_position_ff <= rsp_found_position_in;
      rsp_count_ff          <= rsp_count_in;
      rsp_is_empty_ff       <= rsp_is_empty_in;
      rsp_status_ff         <= rsp_status_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_found_position_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_is_empty       = rsp_is_empty_ff;
   assign rsp_status         = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write hit the same entry");

   a_write_in_run: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_RUN))
      else $error("RAM write outside an operation");

   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted command neither running nor answered");

   a_count_steady_idle: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_IDLE && state_ff == S_IDLE) |-> $stable(count_ff))
      else $error("count changed while idle");

endmodule
